>>> src/lzssw_pkg.sv
package lzssw_pkg;

  localparam int WinAw = 12;
  localparam int WinDepth = 1 << WinAw;
  localparam int ByteW = 8;

  localparam logic [WinAw-1:0] RegionDownBase = 12'h100;
  localparam logic [WinAw-1:0] RegionQuadBase = 12'h200;
  localparam logic [WinAw-1:0] RegionTailBase = 12'h600;

  typedef enum logic [1:0] {
    CMD_LIT   = 2'd0,
    CMD_COPY  = 2'd1,
    CMD_RESET = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic [WinAw-1:0] addr;
    logic [3:0]       len_hi;
    logic             last;
  } cmd_t;

  // Contents of a window entry that has not been written since the stream began.
  function automatic logic [ByteW-1:0] prefill_byte(input logic [WinAw-1:0] a);
    logic [WinAw-1:0] off;
    logic [ByteW-1:0] v;
    off = a - RegionQuadBase;
    if (a < RegionDownBase) begin
      v = a[ByteW-1:0];
    end else if (a < RegionQuadBase) begin
      v = ~a[ByteW-1:0];
    end else if (a < RegionTailBase) begin
      v = off[ByteW+1:2];
    end else begin
      v = a[ByteW-1:0];
    end
    return v;
  endfunction

endpackage

>>> src/lzssw_in_if.sv
interface lzssw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in_stream;

  modport source (output valid, output in_byte, output last_in_stream, input ready);
  modport sink (input valid, input in_byte, input last_in_stream, output ready);
endinterface

>>> src/lzssw_out_if.sv
interface lzssw_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink (input valid, input out_byte, input run_last, input stream_done,
                output ready);
endinterface

>>> src/lzssw_window_decompressor.sv
// Channel   Role      Payload                               Request moves
// in_i      sink      in_byte[7:0], last_in_stream          one compressed byte
// out_o     source    out_byte[7:0], run_last, stream_done  one decompressed byte
//
// A control byte yields no output byte. A literal passes through the back end's S_LIT
// state; each byte of a copy passes through S_RD and then S_WR, as set by the window RAM,
// whose registered read must follow the write of the previous byte.
// After reset or a last byte the window is not swept: a fill count marks the entries
// written so far and every other entry reads as its prefill pattern, so no clearing pass.
// The command queue lets the parser take bytes while the back end copies or is stalled.
module lzss_window_decompressor
  import lzssw_pkg::*;
#(
  parameter int FifoDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzssw_in_if.sink    in_i,
  lzssw_out_if.source out_o
);

  logic cmd_push_valid;
  logic cmd_push_ready;
  cmd_t cmd_push;
  logic cmd_pop_valid;
  logic cmd_pop_ready;
  cmd_t cmd_pop;

  lzssw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_valid_o(cmd_push_valid),
    .cmd_ready_i(cmd_push_ready),
    .cmd_o      (cmd_push)
  );

  lzssw_cmd_fifo #(
    .Depth(FifoDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(cmd_push_valid),
    .push_ready_o(cmd_push_ready),
    .push_data_i (cmd_push),
    .pop_valid_o (cmd_pop_valid),
    .pop_ready_i (cmd_pop_ready),
    .pop_data_o  (cmd_pop)
  );

  lzssw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_pop_valid),
    .cmd_ready_o(cmd_pop_ready),
    .cmd_i      (cmd_pop),
    .out_o      (out_o)
  );

endmodule

>>> src/lzssw_ram.sv
module lzssw_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/lzssw_front.sv
module lzssw_front
  import lzssw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  lzssw_in_if.sink    in_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    MODE_CTRL,
    MODE_LIT,
    MODE_OFS
  } mode_e;

  mode_e      mode_q;
  logic [4:0] lit_left_q;
  logic [7:0] ctrl_q;
  logic       accept;
  logic       need_cmd;

  assign in_i.ready = cmd_ready_i;
  assign accept = in_i.valid && cmd_ready_i;

  always_comb begin
    need_cmd    = 1'b0;
    cmd_o.kind  = CMD_RESET;
    cmd_o.addr  = '0;
    cmd_o.len_hi = ctrl_q[7:4];
    cmd_o.last  = in_i.last_in_stream;
    case (mode_q)
      MODE_LIT: begin
        need_cmd   = 1'b1;
        cmd_o.kind = CMD_LIT;
        cmd_o.addr = {4'b0, in_i.in_byte};
      end
      MODE_OFS: begin
        need_cmd   = 1'b1;
        cmd_o.kind = CMD_COPY;
        cmd_o.addr = {ctrl_q[3:0], in_i.in_byte};
      end
      default: begin
        need_cmd = in_i.last_in_stream;
      end
    endcase
  end

  assign cmd_valid_o = accept && need_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_CTRL;
      lit_left_q <= '0;
      ctrl_q     <= '0;
    end else if (accept) begin
      if (in_i.last_in_stream) begin
        mode_q     <= MODE_CTRL;
        lit_left_q <= '0;
        ctrl_q     <= '0;
      end else begin
        case (mode_q)
          MODE_LIT: begin
            lit_left_q <= lit_left_q - 5'd1;
            if (lit_left_q == 5'd1) begin
              mode_q <= MODE_CTRL;
            end
          end
          MODE_OFS: begin
            mode_q <= MODE_CTRL;
          end
          default: begin
            if (in_i.in_byte[7:4] == 4'h0) begin
              lit_left_q <= {1'b0, in_i.in_byte[3:0]} + 5'd1;
              mode_q     <= MODE_LIT;
            end else begin
              ctrl_q <= in_i.in_byte;
              mode_q <= MODE_OFS;
            end
          end
        endcase
      end
    end
  end

endmodule

>>> src/lzssw_cmd_fifo.sv
module lzssw_cmd_fifo
  import lzssw_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_data_o
);

  localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int Cw = $clog2(Depth + 1);
  localparam logic [Aw-1:0] LastIdx = Aw'(Depth - 1);
  localparam logic [Cw-1:0] Full = Cw'(Depth);

  cmd_t          slot_q [Depth];
  logic [Aw-1:0] wr_q;
  logic [Aw-1:0] rd_q;
  logic [Cw-1:0] cnt_q;
  logic          do_push;
  logic          do_pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = slot_q[rd_q];
  assign do_push = push_valid_i && push_ready_o;
  assign do_pop  = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + Aw'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + Aw'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + Cw'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - Cw'(1);
      end
    end
  end

endmodule

>>> src/lzssw_back.sv
module lzssw_back
  import lzssw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  lzssw_out_if.source out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LIT,
    S_RD,
    S_WR
  } state_e;

  localparam logic [WinAw:0] FillFull = (WinAw + 1)'(WinDepth);

  state_e           state_q;
  logic [WinAw-1:0] wp_q;
  logic [WinAw:0]   fill_q;
  logic [WinAw-1:0] src_q;
  logic [4:0]       cnt_q;
  logic             last_q;
  logic [ByteW-1:0] lit_q;
  logic             pf_q;
  logic [ByteW-1:0] pf_val_q;
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q;
  logic             run_last_q;
  logic             done_q;

  logic             out_free;
  logic             out_load;
  logic             ram_we;
  logic             ram_re;
  logic [ByteW-1:0] ram_wdata;
  logic [ByteW-1:0] ram_rdata;
  logic [ByteW-1:0] copy_val;
  logic [WinAw:0]   fill_inc;

  assign out_free    = !out_valid_q || out_o.ready;
  assign out_load    = ((state_q == S_LIT) || (state_q == S_WR)) && out_free;
  assign cmd_ready_o = (state_q == S_IDLE);
  assign copy_val    = pf_q ? pf_val_q : ram_rdata;
  assign fill_inc    = (fill_q == FillFull) ? fill_q : fill_q + (WinAw + 1)'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = copy_val;
    ram_re    = (state_q == S_RD);
    case (state_q)
      S_LIT: begin
        ram_we    = out_free;
        ram_wdata = lit_q;
      end
      S_WR: begin
        ram_we = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lzssw_ram #(
    .Width(ByteW),
    .Depth(WinDepth)
  ) u_window (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(src_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wp_q        <= '0;
      fill_q      <= '0;
      src_q       <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      lit_q       <= '0;
      pf_q        <= 1'b0;
      pf_val_q    <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      run_last_q  <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            last_q <= cmd_i.last;
            lit_q  <= cmd_i.addr[ByteW-1:0];
            src_q  <= cmd_i.addr;
            cnt_q  <= {1'b0, cmd_i.len_hi} + 5'd1;
            case (cmd_i.kind)
              CMD_LIT:  state_q <= S_LIT;
              CMD_COPY: state_q <= S_RD;
              default: begin
                wp_q   <= '0;
                fill_q <= '0;
              end
            endcase
          end
        end
        S_LIT: begin
          if (out_free) begin
            out_byte_q  <= lit_q;
            run_last_q  <= 1'b1;
            done_q      <= last_q;
            state_q     <= S_IDLE;
            if (last_q) begin
              wp_q   <= '0;
              fill_q <= '0;
            end else begin
              wp_q   <= wp_q + WinAw'(1);
              fill_q <= fill_inc;
            end
          end
        end
        S_RD: begin
          pf_q     <= ({1'b0, src_q} >= fill_q);
          pf_val_q <= prefill_byte(src_q);
          state_q  <= S_WR;
        end
        S_WR: begin
          if (out_free) begin
            out_byte_q  <= copy_val;
            run_last_q  <= (cnt_q == '0);
            done_q      <= (cnt_q == '0) && last_q;
            src_q       <= src_q + WinAw'(1);
            cnt_q       <= cnt_q - 5'd1;
            if ((cnt_q == '0) && last_q) begin
              wp_q   <= '0;
              fill_q <= '0;
            end else begin
              wp_q   <= wp_q + WinAw'(1);
              fill_q <= fill_inc;
            end
            state_q <= (cnt_q == '0) ? S_IDLE : S_RD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_byte    = out_byte_q;
  assign out_o.run_last    = run_last_q;
  assign out_o.stream_done = done_q;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
module tb;
  import lzssw_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 80;

  typedef enum logic [1:0] {
    PARSE_CTRL = 2'd0,
    PARSE_LIT  = 2'd1,
    PARSE_OFS  = 2'd2
  } parse_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             run_last;
    logic             stream_done;
  } dec_byte_t;

  logic clk_i;
  logic rst_ni;

  lzssw_in_if  in_if ();
  lzssw_out_if out_if ();

  lzss_window_decompressor u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [ByteW-1:0] hist [WinDepth];
  logic [WinAw-1:0] hist_wp;
  parse_e           parse_st;
  logic [4:0]       lits_left;
  logic [7:0]       ctrl_held;
  dec_byte_t        pending_bytes [$];

  int n_errors;
  int idle_cycles;
  int burst_left;
  int items_sent;
  bit gaps_on;
  int stall_mode;
  int stall_left;

  function automatic void restart_stream();
    for (int a = 0; a < WinDepth; a++) begin
      if (a < 256) begin
        hist[a] = 8'(a);
      end else if (a < 512) begin
        hist[a] = 8'(511 - a);
      end else if (a < 1536) begin
        hist[a] = 8'((a - 512) >> 2);
      end else begin
        hist[a] = 8'(a);
      end
    end
    hist_wp   = '0;
    parse_st  = PARSE_CTRL;
    lits_left = '0;
    ctrl_held = '0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic [WinAw-1:0] src;
    logic [7:0]       v;
    int               len;
    dec_byte_t        made [$];
    dec_byte_t        d;
    case (parse_st)
      PARSE_LIT: begin
        hist[hist_wp] = b;
        hist_wp = hist_wp + 1'b1;
        d = '{data: b, run_last: 1'b0, stream_done: 1'b0};
        made.push_back(d);
        lits_left = lits_left - 5'd1;
        if (lits_left == 5'd0) parse_st = PARSE_CTRL;
      end
      PARSE_OFS: begin
        src = {ctrl_held[3:0], b};
        len = int'(ctrl_held[7:4]) + 2;
        for (int i = 0; i < len; i++) begin
          v = hist[src];
          hist[hist_wp] = v;
          hist_wp = hist_wp + 1'b1;
          d = '{data: v, run_last: 1'b0, stream_done: 1'b0};
          made.push_back(d);
          src = src + 1'b1;
        end
        parse_st = PARSE_CTRL;
      end
      default: begin
        if (b[7:4] == 4'h0) begin
          lits_left = 5'(b[3:0]) + 5'd1;
          parse_st  = PARSE_LIT;
        end else begin
          ctrl_held = b;
          parse_st  = PARSE_OFS;
        end
      end
    endcase
    if (made.size() > 0) begin
      made[made.size()-1].run_last    = 1'b1;
      made[made.size()-1].stream_done = last;
    end
    foreach (made[i]) pending_bytes.push_back(made[i]);
    if (last) restart_stream();
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    decode_byte(b, last);
    items_sent++;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_if.valid          <= 1'b1;
    in_if.in_byte        <= b;
    in_if.last_in_stream <= last;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic send_literal_run(input int count, input bit last_at_end);
    send_byte(8'(count - 1), 1'b0);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(0, 255)), last_at_end && (i == count - 1));
    end
  endtask

  task automatic send_copy(input logic [3:0] len_code, input logic [WinAw-1:0] src,
                           input bit last_at_end);
    send_byte({len_code, src[11:8]}, 1'b0);
    send_byte(src[7:0], last_at_end);
  endtask

  function automatic logic [WinAw-1:0] pick_source();
    logic [WinAw-1:0] s;
    if ($urandom_range(0, 1) == 0) begin
      s = 12'($urandom_range(0, WinDepth - 1));
    end else begin
      s = hist_wp - 12'($urandom_range(1, 40));
    end
    return s;
  endfunction

  task automatic test_literal_runs();
    gaps_on    = 1'b0;
    stall_mode = 0;
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    for (int i = 0; i < 16; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == 15);
    end
  endtask

  task automatic test_prefill_copies();
    gaps_on    = 1'b1;
    stall_mode = 1;
    send_copy(4'hF, 12'h0F8, 1'b0);
    send_copy(4'h1, 12'h1FE, 1'b0);
    send_copy(4'hF, 12'h5F8, 1'b0);
    send_copy(4'hF, 12'hFF8, 1'b1);
  endtask

  task automatic test_overlap_and_stream_ends();
    logic [WinAw-1:0] wp_now;
    gaps_on    = 1'b1;
    stall_mode = 2;
    send_byte(8'h01, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_copy(4'hF, hist_wp - 1'b1, 1'b0);
    wp_now = hist_wp;
    send_copy(4'h1, wp_now, 1'b0);
    send_byte(8'h35, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_window_wrap();
    logic [3:0] len_code;
    for (int t = 0; t < 90; t++) begin
      if (t % 30 == 0) begin
        stall_mode = (t / 30) % 3;
        gaps_on    = ((t / 30) % 2) != 0;
      end
      if ($urandom_range(0, 7) == 0) begin
        send_literal_run($urandom_range(1, 16), 1'b0);
      end else begin
        len_code = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
        send_copy(len_code, pick_source(), 1'b0);
      end
    end
    send_literal_run(1, 1'b1);
  endtask

  task automatic test_random_streams();
    int  start;
    int  pick;
    bit  stream_end;
    start = items_sent;
    while (items_sent - start < 60) begin
      if ($urandom_range(0, 30) == 0) begin
        stall_mode = $urandom_range(0, 2);
        gaps_on    = 1'($urandom_range(0, 1));
      end
      pick       = $urandom_range(0, 19);
      stream_end = ($urandom_range(0, 9) == 0);
      if (pick < 9) begin
        send_literal_run($urandom_range(1, 16), stream_end);
      end else if (pick < 18) begin
        send_copy(4'($urandom_range(1, 15)), pick_source(), stream_end);
      end else if (pick == 18) begin
        send_byte({4'h0, 4'($urandom_range(1, 15))}, 1'b0);
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_byte({4'($urandom_range(1, 15)), 4'($urandom_range(0, 15))}, 1'b1);
      end
    end
    send_literal_run(1, 1'b1);
  endtask

  task automatic finish_run();
    in_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0 && pending_bytes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left--;
    end else begin
      out_if.ready <= 1'b1;
      case (stall_mode)
        1: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
        2: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 20);
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    dec_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_bytes.size() == 0) begin
        $error("unexpected result: out_byte %0h", out_if.out_byte);
        n_errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_if.out_byte !== want.data) begin
          $error("out_byte: expected %0h, actual %0h", want.data, out_if.out_byte);
          n_errors++;
        end
        if (out_if.run_last !== want.run_last) begin
          $error("run_last: expected %0b, actual %0b", want.run_last, out_if.run_last);
          n_errors++;
        end
        if (out_if.stream_done !== want.stream_done) begin
          $error("stream_done: expected %0b, actual %0b", want.stream_done,
                 out_if.stream_done);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni               = 1'b0;
    in_if.valid          = 1'b0;
    in_if.in_byte        = '0;
    in_if.last_in_stream = 1'b0;
    out_if.ready         = 1'b0;
    n_errors             = 0;
    idle_cycles          = 0;
    burst_left           = 0;
    items_sent           = 0;
    gaps_on              = 1'b0;
    stall_mode           = 0;
    stall_left           = 0;
    restart_stream();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_literal_runs();
    test_prefill_copies();
    test_overlap_and_stream_ends();
    test_window_wrap();
    test_random_streams();
    finish_run();
  end

endmodule
